// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the point-plane distance block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== src/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Widths and the data record handed along the distance search chain.
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int CoordBits = 16;
    localparam int DistBits  = 17;
    localparam int DiffW     = CoordBits + 1;
    localparam int MulW      = 2 * DiffW;
    localparam int CrossW    = MulW + 1;
    localparam int DotPW     = CrossW + DiffW;
    localparam int DotVW     = DotPW + 2;
    localparam int SqW       = 2 * CrossW;
    localparam int NnW       = SqW + 2;
    localparam int HalfW     = (DotVW + 1) / 2;
    localparam int HiW       = DotVW - HalfW;
    localparam int Num2W     = 2 * DotVW;
    localparam int RemW      = Num2W + 2;
    localparam int ProdW     = DistBits + NnW;
    localparam int BitIdxW   = $clog2(DistBits);

    typedef struct packed {
        logic                degen;
        logic [RemW-1:0]     rem;
        logic [ProdW-1:0]    prod;
        logic [NnW-1:0]      nn;
        logic [DistBits-1:0] dval;
    } cell_t;

endpackage

// ===== src/ppd_front.sv =====
// ----------------------------------------------------------------------------
// ppd_front
// Normal, dot products and squared numerator, eight register stages.
// ----------------------------------------------------------------------------
module ppd_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 valid_in,
    input  logic signed [ppd_pkg::CoordBits-1:0] ax,
    input  logic signed [ppd_pkg::CoordBits-1:0] ay,
    input  logic signed [ppd_pkg::CoordBits-1:0] az,
    input  logic signed [ppd_pkg::CoordBits-1:0] bx,
    input  logic signed [ppd_pkg::CoordBits-1:0] by,
    input  logic signed [ppd_pkg::CoordBits-1:0] bz,
    input  logic signed [ppd_pkg::CoordBits-1:0] cx,
    input  logic signed [ppd_pkg::CoordBits-1:0] cy,
    input  logic signed [ppd_pkg::CoordBits-1:0] cz,
    input  logic signed [ppd_pkg::CoordBits-1:0] qx,
    input  logic signed [ppd_pkg::CoordBits-1:0] qy,
    input  logic signed [ppd_pkg::CoordBits-1:0] qz,
    output logic                                 valid_out,
    output ppd_pkg::cell_t                       data_out
);

    localparam int DiffW  = ppd_pkg::DiffW;
    localparam int MulW   = ppd_pkg::MulW;
    localparam int CrossW = ppd_pkg::CrossW;
    localparam int DotPW  = ppd_pkg::DotPW;
    localparam int DotVW  = ppd_pkg::DotVW;
    localparam int SqW    = ppd_pkg::SqW;
    localparam int NnW    = ppd_pkg::NnW;
    localparam int HalfW  = ppd_pkg::HalfW;
    localparam int HiW    = ppd_pkg::HiW;
    localparam int RemW   = ppd_pkg::RemW;

    logic [7:0] valid_reg;

    logic signed [DiffW-1:0] ux_reg, uy_reg, uz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [DiffW-1:0] vx1_reg, vy1_reg, vz1_reg;
    logic signed [MulW-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DiffW-1:0] vx2_reg, vy2_reg, vz2_reg;
    logic signed [CrossW-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [DiffW-1:0] vx3_reg, vy3_reg, vz3_reg;
    logic signed [DotPW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [SqW-1:0]   sx_reg, sy_reg, sz_reg;
    logic                    degen4_reg;
    logic signed [DotVW-1:0] num_reg;
    logic [NnW-1:0]          nn5_reg;
    logic                    degen5_reg;
    logic [DotVW-1:0]        abs_reg;
    logic [NnW-1:0]          nn6_reg;
    logic                    degen6_reg;
    logic [2*HiW-1:0]        hh_reg;
    logic [DotVW-1:0]        hl_reg;
    logic [2*HalfW-1:0]      ll_reg;
    logic [NnW-1:0]          nn7_reg;
    logic                    degen7_reg;
    ppd_pkg::cell_t          out_reg;

    logic signed [NnW-1:0]   nn_sum;
    logic [DotVW-1:0]        num_abs;
    logic [HiW-1:0]          hi;
    logic [HalfW-1:0]        lo;

    assign nn_sum  = NnW'(sx_reg) + NnW'(sy_reg) + NnW'(sz_reg);
    assign num_abs = num_reg[DotVW-1] ? DotVW'(-num_reg) : DotVW'(num_reg);
    assign hi      = abs_reg[DotVW-1:HalfW];
    assign lo      = abs_reg[HalfW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[6:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg  <= DiffW'(bx) - DiffW'(ax);
            uy_reg  <= DiffW'(by) - DiffW'(ay);
            uz_reg  <= DiffW'(bz) - DiffW'(az);
            wx_reg  <= DiffW'(cx) - DiffW'(ax);
            wy_reg  <= DiffW'(cy) - DiffW'(ay);
            wz_reg  <= DiffW'(cz) - DiffW'(az);
            vx1_reg <= DiffW'(qx) - DiffW'(ax);
            vy1_reg <= DiffW'(qy) - DiffW'(ay);
            vz1_reg <= DiffW'(qz) - DiffW'(az);

            p0_reg  <= MulW'(uy_reg) * MulW'(wz_reg);
            p1_reg  <= MulW'(uz_reg) * MulW'(wy_reg);
            p2_reg  <= MulW'(uz_reg) * MulW'(wx_reg);
            p3_reg  <= MulW'(ux_reg) * MulW'(wz_reg);
            p4_reg  <= MulW'(ux_reg) * MulW'(wy_reg);
            p5_reg  <= MulW'(uy_reg) * MulW'(wx_reg);
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            vz2_reg <= vz1_reg;

            nx_reg  <= CrossW'(p0_reg) - CrossW'(p1_reg);
            ny_reg  <= CrossW'(p2_reg) - CrossW'(p3_reg);
            nz_reg  <= CrossW'(p4_reg) - CrossW'(p5_reg);
            vx3_reg <= vx2_reg;
            vy3_reg <= vy2_reg;
            vz3_reg <= vz2_reg;

            dx_reg     <= DotPW'(nx_reg) * DotPW'(vx3_reg);
            dy_reg     <= DotPW'(ny_reg) * DotPW'(vy3_reg);
            dz_reg     <= DotPW'(nz_reg) * DotPW'(vz3_reg);
            sx_reg     <= SqW'(nx_reg) * SqW'(nx_reg);
            sy_reg     <= SqW'(ny_reg) * SqW'(ny_reg);
            sz_reg     <= SqW'(nz_reg) * SqW'(nz_reg);
            degen4_reg <= (nx_reg == '0) && (ny_reg == '0) && (nz_reg == '0);

            num_reg    <= DotVW'(dx_reg) + DotVW'(dy_reg) + DotVW'(dz_reg);
            nn5_reg    <= NnW'(unsigned'(nn_sum));
            degen5_reg <= degen4_reg;

            abs_reg    <= num_abs;
            nn6_reg    <= nn5_reg;
            degen6_reg <= degen5_reg;

            hh_reg     <= (2*HiW)'(hi) * (2*HiW)'(hi);
            hl_reg     <= DotVW'(hi) * DotVW'(lo);
            ll_reg     <= (2*HalfW)'(lo) * (2*HalfW)'(lo);
            nn7_reg    <= nn6_reg;
            degen7_reg <= degen6_reg;

            out_reg.rem   <= (RemW'(hh_reg) << (2*HalfW))
                           + (RemW'(hl_reg) << (HalfW + 1))
                           + RemW'(ll_reg);
            out_reg.prod  <= '0;
            out_reg.nn    <= nn7_reg;
            out_reg.dval  <= '0;
            out_reg.degen <= degen7_reg;
        end
    end

    assign valid_out = valid_reg[7];
    assign data_out  = out_reg;

endmodule

// ===== src/ppd_cell.sv =====
// ----------------------------------------------------------------------------
// ppd_cell
// One step of the distance search: try one bit of d, keep it if it fits.
// ----------------------------------------------------------------------------
module ppd_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [ppd_pkg::BitIdxW-1:0]   bit_idx,
    input  logic                          valid_in,
    input  ppd_pkg::cell_t                data_in,
    output logic                          valid_out,
    output ppd_pkg::cell_t                data_out
);

    localparam int RemW  = ppd_pkg::RemW;
    localparam int ProdW = ppd_pkg::ProdW;
    localparam int DistBits = ppd_pkg::DistBits;

    logic                valid_reg;
    ppd_pkg::cell_t      data_reg;
    ppd_pkg::cell_t      data_next;
    logic [RemW-1:0]     trial;
    logic [RemW:0]       diff;
    logic                take;

    assign trial = (RemW'(data_in.prod) << (bit_idx + 1'b1))
                 + (RemW'(data_in.nn) << ({1'b0, bit_idx} << 1));
    assign diff  = {1'b0, data_in.rem} - {1'b0, trial};
    assign take  = !diff[RemW];

    always_comb
    begin
        data_next = data_in;
        if (take)
        begin
            data_next.rem  = diff[RemW-1:0];
            data_next.prod = data_in.prod + (ProdW'(data_in.nn) << bit_idx);
            data_next.dval = data_in.dval | (DistBits'(1) << bit_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== src/point_plane_distance.sv =====
// ----------------------------------------------------------------------------
// point_plane_distance
// Distance from a query point to the plane through three points.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with twelve signed coordinates per item
// (plane points a, b, c and query point q). Output channel: out_valid /
// out_stall with distance and degenerate.
// Throughput: one item per cycle while the pipeline is not held; every item
// gives exactly one result. Stages: eight front stages for the normal, the
// dot products and the squared numerator, seventeen search cells (one per
// distance bit, most significant first), one output register.
// The whole pipeline advances together; it holds while the output register
// is full and out_stall is high, and in_stall follows that condition.
// A result with degenerate set has distance 0.
// Reset clears all valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_plane_distance (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [ppd_pkg::CoordBits-1:0] ax,
    input  logic signed [ppd_pkg::CoordBits-1:0] ay,
    input  logic signed [ppd_pkg::CoordBits-1:0] az,
    input  logic signed [ppd_pkg::CoordBits-1:0] bx,
    input  logic signed [ppd_pkg::CoordBits-1:0] by,
    input  logic signed [ppd_pkg::CoordBits-1:0] bz,
    input  logic signed [ppd_pkg::CoordBits-1:0] cx,
    input  logic signed [ppd_pkg::CoordBits-1:0] cy,
    input  logic signed [ppd_pkg::CoordBits-1:0] cz,
    input  logic signed [ppd_pkg::CoordBits-1:0] qx,
    input  logic signed [ppd_pkg::CoordBits-1:0] qy,
    input  logic signed [ppd_pkg::CoordBits-1:0] qz,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ppd_pkg::DistBits-1:0]         distance,
    output logic                                 degenerate
);

    localparam int DistBits = ppd_pkg::DistBits;

    logic                 en;
    logic                 out_valid_reg;
    logic [DistBits-1:0]  distance_reg;
    logic                 degenerate_reg;
    logic                 front_valid;
    ppd_pkg::cell_t       front_data;
    logic                 chain_valid [DistBits+1];
    ppd_pkg::cell_t       chain_data [DistBits+1];
    logic [DistBits-1:0]  cell_valids;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    ppd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .ax        (ax),
        .ay        (ay),
        .az        (az),
        .bx        (bx),
        .by        (by),
        .bz        (bz),
        .cx        (cx),
        .cy        (cy),
        .cz        (cz),
        .qx        (qx),
        .qy        (qy),
        .qz        (qz),
        .valid_out (front_valid),
        .data_out  (front_data)
    );

    assign chain_valid[0] = front_valid;
    assign chain_data[0]  = front_data;

    for (genvar i = 0; i < DistBits; i++)
    begin : g_cell
        ppd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .bit_idx   (ppd_pkg::BitIdxW'(DistBits - 1 - i)),
            .valid_in  (chain_valid[i]),
            .data_in   (chain_data[i]),
            .valid_out (chain_valid[i+1]),
            .data_out  (chain_data[i+1])
        );
        assign cell_valids[i] = chain_valid[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain_valid[DistBits];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            distance_reg   <= chain_data[DistBits].degen ? '0 : chain_data[DistBits].dval;
            degenerate_reg <= chain_data[DistBits].degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign distance   = distance_reg;
    assign degenerate = degenerate_reg;

    `ASSERT_IMPLY(a_degen_zero, clk, rst_n, out_valid && degenerate, distance == '0)
    `ASSERT_NEXT(a_hold_chain, clk, rst_n, !en, $stable(cell_valids))
    `ASSERT_IMPLY(a_stall_full, clk, rst_n, in_stall, out_valid && out_stall)

endmodule
